### sv/skt_pkg.sv
// Package: types, constants and codes shared by the sorted key table modules.
package skt_pkg;

    localparam int CAPACITY    = 64;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS    = $clog2(CAPACITY + 1);

    localparam int KEY_BITS     = 32;
    localparam int IN_HDL_BITS  = 16;
    localparam int POS_BITS     = 7;
    localparam int OUT_HDL_BITS = 16;
    localparam int OUT_CNT_BITS = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_DUP  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                    op;
        logic [KEY_BITS-1:0]    key;
        logic [IN_HDL_BITS-1:0] handle;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [POS_BITS-1:0]     position;
        logic [OUT_HDL_BITS-1:0] found_handle;
        logic [OUT_CNT_BITS-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_BITS-1:0]   wr_addr;
        logic [KEY_BITS-1:0]    wr_key;
        logic [HANDLE_BITS-1:0] wr_handle;
        logic [ADDR_BITS-1:0]   rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic [KEY_BITS-1:0]    rd_key;
        logic [HANDLE_BITS-1:0] rd_handle;
    } t_mem_rsp;

endpackage

### sv/skt_store.sv
// Entry store: key and handle arrays with one write port and one registered read port.
module skt_store (
    input  logic              i_clk,
    input  skt_pkg::t_mem_req i_mem,
    output skt_pkg::t_mem_rsp o_rsp
);

    logic [skt_pkg::KEY_BITS-1:0]    r_keys    [skt_pkg::CAPACITY];
    logic [skt_pkg::HANDLE_BITS-1:0] r_handles [skt_pkg::CAPACITY];
    skt_pkg::t_mem_rsp               r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_keys[i_mem.wr_addr]    <= i_mem.wr_key;
            r_handles[i_mem.wr_addr] <= i_mem.wr_handle;
        end
        r_rsp.rd_key    <= r_keys[i_mem.rd_addr];
        r_rsp.rd_handle <= r_handles[i_mem.rd_addr];
    end

    assign o_rsp = r_rsp;

endmodule

### sv/skt_seq.sv
// Sequencer: binary search, entry shifting and result forming over the shared store port.
module skt_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  skt_pkg::t_req     i_req,
    input  logic              i_res_ready,
    input  skt_pkg::t_mem_rsp i_rsp,
    output logic              o_s_ready,
    output logic              o_res_valid,
    output skt_pkg::t_result  o_res,
    output skt_pkg::t_mem_req o_mem
);

    localparam int CW = skt_pkg::CNT_BITS;
    localparam int AW = skt_pkg::ADDR_BITS;

    skt_pkg::t_state                 r_state,  n_state;
    skt_pkg::t_op                    r_op,     n_op;
    logic [skt_pkg::KEY_BITS-1:0]    r_key,    n_key;
    logic [skt_pkg::HANDLE_BITS-1:0] r_handle, n_handle;
    logic [CW-1:0]                   r_lo,     n_lo;
    logic [CW-1:0]                   r_hi,     n_hi;
    logic [CW-1:0]                   r_idx,    n_idx;
    logic [CW-1:0]                   r_pos,    n_pos;
    logic [CW-1:0]                   r_count,  n_count;
    skt_pkg::t_status                r_status, n_status;
    logic [skt_pkg::HANDLE_BITS-1:0] r_found,  n_found;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          key_less;
    logic          key_eq;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign key_less = $signed(i_rsp.rd_key) < $signed(r_key);
    assign key_eq   = i_rsp.rd_key == r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_handle <= n_handle;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_key         = r_key;
        n_handle      = r_handle;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_count       = r_count;
        n_status      = r_status;
        n_found       = r_found;
        o_mem.wr_en     = 1'b0;
        o_mem.wr_addr   = AW'(r_idx);
        o_mem.wr_key    = i_rsp.rd_key;
        o_mem.wr_handle = i_rsp.rd_handle;
        o_mem.rd_addr   = AW'(mid);
        o_res_valid   = 1'b0;
        case (r_state)
            skt_pkg::ST_IDLE: begin
                if (i_acc) begin
                    n_op     = i_req.op;
                    n_key    = i_req.key;
                    n_handle = skt_pkg::HANDLE_BITS'(i_req.handle);
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_pos    = '0;
                    n_found  = '0;
                    if (i_req.op == skt_pkg::OP_RSVD) begin
                        n_status = skt_pkg::STAT_MISS;
                        n_state  = skt_pkg::ST_DONE;
                    end else if (i_req.op == skt_pkg::OP_INSERT &&
                                 r_count == CW'(skt_pkg::CAPACITY)) begin
                        n_status = skt_pkg::STAT_FULL;
                        n_state  = skt_pkg::ST_DONE;
                    end else begin
                        n_state = skt_pkg::ST_SRCH;
                    end
                end
            end
            skt_pkg::ST_SRCH: begin
                if (r_lo < r_hi) begin
                    o_mem.rd_addr = AW'(mid);
                    n_state       = skt_pkg::ST_CMP;
                end else begin
                    n_pos = r_lo;
                    if (r_lo < r_count) begin
                        o_mem.rd_addr = AW'(r_lo);
                        n_state       = skt_pkg::ST_CHK;
                    end else if (r_op == skt_pkg::OP_INSERT) begin
                        n_idx   = r_count;
                        n_state = skt_pkg::ST_INS_RD;
                    end else begin
                        n_status = skt_pkg::STAT_MISS;
                        n_state  = skt_pkg::ST_DONE;
                    end
                end
            end
            skt_pkg::ST_CMP: begin
                if (key_less) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = skt_pkg::ST_SRCH;
            end
            skt_pkg::ST_CHK: begin
                if (key_eq) begin
                    n_found  = i_rsp.rd_handle;
                    n_status = (r_op == skt_pkg::OP_INSERT) ? skt_pkg::STAT_DUP
                                                            : skt_pkg::STAT_OK;
                    if (r_op == skt_pkg::OP_REMOVE) begin
                        n_idx   = r_pos;
                        n_state = skt_pkg::ST_REM_RD;
                    end else begin
                        n_state = skt_pkg::ST_DONE;
                    end
                end else if (r_op == skt_pkg::OP_INSERT) begin
                    n_idx   = r_count;
                    n_state = skt_pkg::ST_INS_RD;
                end else begin
                    n_status = skt_pkg::STAT_MISS;
                    n_state  = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_INS_RD: begin
                if (r_idx > r_pos) begin
                    o_mem.rd_addr = AW'(r_idx - CW'(1));
                    n_state       = skt_pkg::ST_INS_WR;
                end else begin
                    o_mem.wr_en     = 1'b1;
                    o_mem.wr_addr   = AW'(r_pos);
                    o_mem.wr_key    = r_key;
                    o_mem.wr_handle = r_handle;
                    n_count         = r_count + CW'(1);
                    n_status        = skt_pkg::STAT_OK;
                    n_state         = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_INS_WR: begin
                o_mem.wr_en = 1'b1;
                n_idx       = r_idx - CW'(1);
                n_state     = skt_pkg::ST_INS_RD;
            end
            skt_pkg::ST_REM_RD: begin
                if ((r_idx + CW'(1)) < r_count) begin
                    o_mem.rd_addr = AW'(r_idx + CW'(1));
                    n_state       = skt_pkg::ST_REM_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = skt_pkg::ST_DONE;
                end
            end
            skt_pkg::ST_REM_WR: begin
                o_mem.wr_en = 1'b1;
                n_idx       = r_idx + CW'(1);
                n_state     = skt_pkg::ST_REM_RD;
            end
            skt_pkg::ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = skt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_s_ready          = r_state == skt_pkg::ST_IDLE;
    assign o_res.status       = r_status;
    assign o_res.position     = skt_pkg::POS_BITS'(r_pos);
    assign o_res.found_handle = skt_pkg::OUT_HDL_BITS'(r_found);
    assign o_res.entry_count  = skt_pkg::OUT_CNT_BITS'(r_count);

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skt_pkg::ST_SRCH |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search window outside live entries");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skt_pkg::ST_INS_RD && r_idx == r_pos)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not advance entry count");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (r_state == skt_pkg::ST_INS_RD || r_state == skt_pkg::ST_INS_WR ||
                         r_state == skt_pkg::ST_REM_WR))
        else $error("store written outside shift or insert");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skt_pkg::ST_DONE && !i_res_ready) |=> r_state == skt_pkg::ST_DONE)
        else $error("result dropped while output full");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skt_pkg::ST_DONE |-> r_count <= CW'(skt_pkg::CAPACITY))
        else $error("entry count above capacity");

endmodule

### sv/sorted_key_table.sv
// Top level: sorted key table with stream request and result channels.
// Usage: each request on the slave side (i_s_*) inserts, removes or looks up one
// entry by a signed 32-bit key; i_s_tuser carries the operation, i_s_tdata the key
// and the handle. Exactly one result per request leaves on the master side (o_m_*):
// o_m_tuser carries the status, o_m_tdata the position, the handle found and the
// live entry count.
// A request is worked on alone. Each binary search halving step reads the store,
// then compares; when the search ends on a live entry, one check read follows.
// An insert then moves the entries above its place one at a time, a remove the
// entries after its place likewise. Lookups, misses and duplicate inserts end
// after the check read, or after the search when its place lies past the last
// entry; an insert into a full table and the unused operation code answer without a
// search. Every search step, check and move uses the single store read port.
// o_s_tready is high only while the sequencer is idle.
// Reset clears the entry count and the control state; the store is not cleared.
// A stalled receiver holds the result in the output register; the next request is
// still taken and worked on, and its result waits until the register frees.
module sorted_key_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // [31:0] frame_key, [47:32] item_handle
    input  logic [1:0]  i_s_tuser,  // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [6:0] position, [22:7] found_handle,
                                    // [29:23] entry_count, [31:30] zero
    output logic [1:0]  o_m_tuser   // [1:0] status
);

    skt_pkg::t_req     req;
    skt_pkg::t_result  res;
    skt_pkg::t_result  r_res;
    skt_pkg::t_mem_req mem_req;
    skt_pkg::t_mem_rsp mem_rsp;
    logic              s_ready;
    logic              s_acc;
    logic              res_valid;
    logic              res_ready;
    logic              r_m_tvalid;

    assign req.op     = skt_pkg::t_op'(i_s_tuser);
    assign req.key    = i_s_tdata[31:0];
    assign req.handle = i_s_tdata[47:32];
    assign o_s_tready = s_ready;
    assign s_acc      = i_s_tvalid && s_ready;
    assign res_ready  = !r_m_tvalid || i_m_tready;

    skt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (s_acc),
        .i_req       (req),
        .i_res_ready (res_ready),
        .i_rsp       (mem_rsp),
        .o_s_ready   (s_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem       (mem_req)
    );

    skt_store u_store (
        .i_clk (i_clk),
        .i_mem (mem_req),
        .o_rsp (mem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {2'b00, r_res.entry_count, r_res.found_handle, r_res.position};

endmodule

### test/sorted_key_table_tb.sv
// Testbench for sorted_key_table: random and directed table requests checked against a predictor.
`timescale 1ns / 1ps

module sorted_key_table_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int PHASE_ITEMS    = 200;
    localparam int PHASE_COUNT    = 7;

    class key_table_scoreboard;
        int                expected_dummy;
        int                keys[skt_pkg::CAPACITY];
        logic [15:0]       handles[skt_pkg::CAPACITY];
        int                count;
        skt_pkg::t_result  expected_q[$];
        int                errors;

        function int lower_bound(int k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = count;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (keys[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void note_request(skt_pkg::t_op op, int k, logic [15:0] h);
            skt_pkg::t_result r;
            int               p;
            int               i;
            bit               hit;
            r.status       = skt_pkg::STAT_MISS;
            r.position     = '0;
            r.found_handle = '0;
            case (op)
                skt_pkg::OP_INSERT: begin
                    if (count >= skt_pkg::CAPACITY) begin
                        r.status = skt_pkg::STAT_FULL;
                    end else begin
                        p          = lower_bound(k);
                        hit        = (p < count) && (keys[p] == k);
                        r.position = 7'(p);
                        if (hit) begin
                            r.status       = skt_pkg::STAT_DUP;
                            r.found_handle = handles[p];
                        end else begin
                            for (i = count; i > p; i--) begin
                                keys[i]    = keys[i-1];
                                handles[i] = handles[i-1];
                            end
                            keys[p]    = k;
                            handles[p] = h;
                            count++;
                            r.status = skt_pkg::STAT_OK;
                        end
                    end
                end
                skt_pkg::OP_REMOVE, skt_pkg::OP_LOOKUP: begin
                    p          = lower_bound(k);
                    hit        = (p < count) && (keys[p] == k);
                    r.position = 7'(p);
                    if (hit) begin
                        r.status       = skt_pkg::STAT_OK;
                        r.found_handle = handles[p];
                        if (op == skt_pkg::OP_REMOVE) begin
                            for (i = p; i + 1 < count; i++) begin
                                keys[i]    = keys[i+1];
                                handles[i] = handles[i+1];
                            end
                            count--;
                        end
                    end
                end
                default: ;
            endcase
            r.entry_count = 7'(count);
            expected_q.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] user);
            skt_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tuser %0d tdata %h",
                         $time, user, data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("status", want.status, user);
            compare("position", want.position, data[6:0]);
            compare("found_handle", want.found_handle, data[22:7]);
            compare("entry_count", want.entry_count, data[29:23]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    key_table_scoreboard sb = new;
    bit send_steady;
    bit recv_steady;
    int idle_cycles;

    sorted_key_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic push_request(skt_pkg::t_op op, int k, logic [15:0] h);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {h, k};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(op, k, h);
    endtask

    function automatic int pick_key(int hit_pct);
        int r;
        if (sb.count > 0 && $urandom_range(0, 99) < hit_pct) begin
            return sb.keys[$urandom_range(0, sb.count - 1)];
        end
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return int'($urandom_range(0, 40)) - 20;
        end else if (r < 50) begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h8000_0001;
                2: return 32'h7FFF_FFFF;
                3: return 32'h7FFF_FFFE;
                4: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic skt_pkg::t_op pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 65) return skt_pkg::OP_INSERT;
            if (r < 80) return skt_pkg::OP_REMOVE;
            if (r < 95) return skt_pkg::OP_LOOKUP;
        end else begin
            if (r < 15) return skt_pkg::OP_INSERT;
            if (r < 75) return skt_pkg::OP_REMOVE;
            if (r < 95) return skt_pkg::OP_LOOKUP;
        end
        return skt_pkg::OP_RSVD;
    endfunction

    function automatic logic [15:0] pick_handle();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_request(bit filling);
        skt_pkg::t_op op;
        int           k;
        op = pick_op(filling);
        case (op)
            skt_pkg::OP_INSERT: k = pick_key(15);
            skt_pkg::OP_REMOVE: k = pick_key(75);
            skt_pkg::OP_LOOKUP: k = pick_key(50);
            default:            k = pick_key(20);
        endcase
        push_request(op, k, pick_handle());
    endtask

    initial begin
        m_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            repeat (recv_steady ? 0 : $urandom_range(0, 8)) begin
                m_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, sb.expected_q.size());
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= skt_pkg::OP_INSERT;
        send_steady = 1'b0;
        recv_steady = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_request(skt_pkg::OP_LOOKUP, 5, 16'h1234);
        push_request(skt_pkg::OP_REMOVE, 5, 16'h0000);
        push_request(skt_pkg::OP_RSVD,   0, 16'h0000);
        push_request(skt_pkg::OP_INSERT, 0, 16'hFFFF);
        push_request(skt_pkg::OP_INSERT, 32'h8000_0000, 16'h0000);
        push_request(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'hA5A5);
        push_request(skt_pkg::OP_INSERT, -1, 16'h5A5A);
        push_request(skt_pkg::OP_INSERT, 0, 16'h0001);
        push_request(skt_pkg::OP_LOOKUP, 32'h8000_0000, 16'hFFFF);
        push_request(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
        push_request(skt_pkg::OP_LOOKUP, 7, 16'h0000);
        push_request(skt_pkg::OP_REMOVE, -1, 16'h0000);
        push_request(skt_pkg::OP_REMOVE, -1, 16'h0000);
        push_request(skt_pkg::OP_RSVD,   32'h7FFF_FFFF, 16'hFFFF);
        push_request(skt_pkg::OP_INSERT, 1, 16'h8000);
        push_request(skt_pkg::OP_LOOKUP, 0, 16'h0000);
        push_request(skt_pkg::OP_REMOVE, 32'h8000_0000, 16'h0000);
        push_request(skt_pkg::OP_REMOVE, 32'h7FFF_FFFF, 16'h0000);
        push_request(skt_pkg::OP_REMOVE, 0, 16'h0000);
        push_request(skt_pkg::OP_REMOVE, 1, 16'h0000);
        push_request(skt_pkg::OP_LOOKUP, 1, 16'h0000);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            send_steady = ($urandom_range(0, 3) == 0);
            recv_steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) random_request(ph % 2 == 0);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/skt_pkg.sv
sv/skt_store.sv
sv/skt_seq.sv
sv/sorted_key_table.sv
test/sorted_key_table_tb.sv
